// ===== hdl/pfb_pkg.sv =====
// Shared types and constants for the pixel fill blend block.
`default_nettype none
package pfb_pkg;

    localparam int unsigned PIX_W   = 32;
    localparam int unsigned LANE_W  = 8;
    localparam int unsigned LANES   = PIX_W / LANE_W;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned CIDX_W  = 8;

    localparam logic [LANE_W-1:0]   LANE_MAX = 8'd255;

    typedef logic [PIX_W-1:0]  t_pixel;
    typedef logic [LANE_W-1:0] t_lane;
    typedef logic [CIDX_W-1:0] t_cfg_idx;

    // Blend mode codes; codes above MODE_MUL pass the pixel through.
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MIN = 3'd2,
        MODE_MAX = 3'd3,
        MODE_MUL = 3'd4
    } t_blend_mode;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_FILL_COLOR  = 8'd0;
    localparam t_cfg_idx CFG_BLEND_MODE  = 8'd1;
    localparam t_cfg_idx CFG_ALPHA_MASK  = 8'd2;
    localparam t_cfg_idx CFG_BLEND_ALPHA = 8'd3;

endpackage
`default_nettype wire

// ===== hdl/pfb_ifs.sv =====
// Channel interfaces of the pixel fill blend block: pixel in, pixel out, config write.
`default_nettype none
interface pfb_dst_if;
    logic            valid;
    logic            ready;
    pfb_pkg::t_pixel dst_pixel;

    modport source (output valid, output dst_pixel, input ready);
    modport sink   (input valid, input dst_pixel, output ready);
endinterface

interface pfb_out_if;
    logic            valid;
    logic            ready;
    pfb_pkg::t_pixel out_pixel;

    modport source (output valid, output out_pixel, input ready);
    modport sink   (input valid, input out_pixel, output ready);
endinterface

interface pfb_cfg_if;
    logic              valid;
    logic              ready;
    pfb_pkg::t_cfg_idx index;
    pfb_pkg::t_pixel   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pixel_fill_blend.sv =====
// Top level of the pixel fill blend block: two-stage per-pixel blend with a fill color.
//
// Usage:
//   i_cfg  - configuration write channel. Index 0 fill color, 1 blend mode,
//            2 alpha mask, 3 blend alpha; other indexes are dropped. Always
//            ready; write only while no pixel request is in flight.
//   i_dst  - destination pixel requests, one 32-bit pixel each.
//   o_res  - blended pixel results, one per request, in order.
//   Each pixel is split into four byte lanes, each lane blended with the
//   matching byte of the fill color (saturating add/sub, min, max, or
//   multiply rounded as (d*c+255)>>8). With blend alpha off and a nonzero
//   mask, the color's alpha bits are forced so destination alpha is kept.
// Timing:
//   An accepted request passes through the input register, then the four
//   lane units (one 8x8 multiplier each) feed the result register.
//   Throughput is one pixel per cycle while o_res.ready is high.
// Reset: i_rst_n low (synchronous) empties both stages and clears the config registers.
// Stall:
//   When o_res.ready is low the result register holds, the input stage fills
//   and holds, and only then does i_dst.ready drop. Nothing is lost.
`default_nettype none
module pixel_fill_blend (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pfb_cfg_if.sink   i_cfg,
    pfb_dst_if.sink   i_dst,
    pfb_out_if.source o_res
);
    import pfb_pkg::*;

    // Configuration registers
    t_pixel            r_fill_color;
    logic [MODE_W-1:0] r_blend_mode;
    t_pixel            r_alpha_mask;
    logic              r_blend_alpha;

    // Pipeline registers
    logic   r_s1_valid;
    t_pixel r_s1_pixel;
    logic   r_out_valid;
    t_pixel r_out_pixel;

    logic   advance;
    t_pixel color;
    t_pixel n_out_pixel;

    // Config writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_color  <= '0;
            r_blend_mode  <= '0;
            r_alpha_mask  <= '0;
            r_blend_alpha <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FILL_COLOR:  r_fill_color  <= i_cfg.data;
                CFG_BLEND_MODE:  r_blend_mode  <= i_cfg.data[MODE_W-1:0];
                CFG_ALPHA_MASK:  r_alpha_mask  <= i_cfg.data;
                CFG_BLEND_ALPHA: r_blend_alpha <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Advance stage 1 into the result register when it is empty or drained
    assign advance     = !r_out_valid || o_res.ready;
    assign i_dst.ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_dst.ready) begin
            r_s1_valid <= i_dst.valid;
        end
    end

    // Hold the pixel while stalled
    always_ff @(posedge i_clk) begin
        if (i_dst.ready && i_dst.valid) begin
            r_s1_pixel <= i_dst.dst_pixel;
        end
    end

    // Protect destination alpha: force color alpha to the neutral value
    always_comb begin
        color = r_fill_color;
        if (!r_blend_alpha && (r_alpha_mask != '0)) begin
            if (r_blend_mode == MODE_MIN || r_blend_mode == MODE_MUL) begin
                color = r_fill_color | r_alpha_mask;
            end else begin
                color = r_fill_color & ~r_alpha_mask;
            end
        end
    end

    // Per-lane blend
    always_comb begin
        logic [LANE_W:0]     sum;
        logic [2*LANE_W-1:0] prod;
        t_lane               d;
        t_lane               c;
        n_out_pixel = r_s1_pixel;
        for (int unsigned ln = 0; ln < LANES; ln++) begin
            d    = r_s1_pixel[ln*LANE_W +: LANE_W];
            c    = color[ln*LANE_W +: LANE_W];
            sum  = {1'b0, d} + {1'b0, c};
            prod = {{LANE_W{1'b0}}, d} * {{LANE_W{1'b0}}, c}
                   + {{LANE_W{1'b0}}, LANE_MAX};
            case (r_blend_mode)
                MODE_ADD: n_out_pixel[ln*LANE_W +: LANE_W] =
                              sum[LANE_W] ? LANE_MAX : sum[LANE_W-1:0];
                MODE_SUB: n_out_pixel[ln*LANE_W +: LANE_W] =
                              (d > c) ? t_lane'(d - c) : '0;
                MODE_MIN: n_out_pixel[ln*LANE_W +: LANE_W] = (d < c) ? d : c;
                MODE_MAX: n_out_pixel[ln*LANE_W +: LANE_W] = (d > c) ? d : c;
                MODE_MUL: n_out_pixel[ln*LANE_W +: LANE_W] =
                              prod[2*LANE_W-1:LANE_W];
                default:  n_out_pixel[ln*LANE_W +: LANE_W] = d;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_pixel <= n_out_pixel;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_pixel = r_out_pixel;

    // Assertions
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1_pixel)))
        else $error("stage 1 dropped or changed a stalled request");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dst.valid && i_dst.ready) |=> r_s1_valid)
        else $error("accepted request did not reach stage 1");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && advance) |=> r_out_valid)
        else $error("stage 1 request did not reach the result register");

    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_dst.ready |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with an empty stage");

    a_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && advance && r_blend_mode > MODE_MUL)
        |=> (r_out_pixel == $past(r_s1_pixel)))
        else $error("unused mode did not pass the pixel through");

endmodule
`default_nettype wire

// ===== tb/pfb_blend_checker.sv =====
// Watcher of the pixel fill blend channels: predicts every blended pixel and compares it.
`default_nettype none
module pfb_blend_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pfb_cfg_if        i_cfg,
    pfb_dst_if        i_dst,
    pfb_out_if        i_res,
    output int        o_fail_count,
    output int        o_pending
);
    import pfb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Mirror of the block's registers, updated on every accepted write to their indexes.
    t_pixel              fill_color;
    logic [MODE_W-1:0]   blend_mode;
    t_pixel              alpha_mask;
    logic                blend_alpha;

    t_pixel              blended_q[$];
    t_pixel              want;
    int                  fail_total;

    function automatic t_pixel blend_pixel(input t_pixel dst, input t_pixel fill,
                                           input logic [MODE_W-1:0] mode,
                                           input t_pixel mask, input logic keep_off);
        t_pixel      color;
        t_pixel      res;
        t_lane       d;
        t_lane       c;
        logic [8:0]  sum;
        logic [15:0] prod;
        int          lane;
        if (mode > MODE_MUL) begin
            return dst;
        end
        color = fill;
        // Force the alpha bits so the destination alpha survives the blend.
        if (!keep_off && mask != '0) begin
            if (mode == MODE_MIN || mode == MODE_MUL) begin
                color = color | mask;
            end else begin
                color = color & ~mask;
            end
        end
        res = '0;
        for (lane = 0; lane < LANES; lane++) begin
            d = dst[lane*LANE_W +: LANE_W];
            c = color[lane*LANE_W +: LANE_W];
            case (mode)
                MODE_ADD: begin
                    sum = {1'b0, d} + {1'b0, c};
                    res[lane*LANE_W +: LANE_W] = sum[LANE_W] ? LANE_MAX : sum[LANE_W-1:0];
                end
                MODE_SUB: begin
                    res[lane*LANE_W +: LANE_W] = (d > c) ? d - c : '0;
                end
                MODE_MIN: begin
                    res[lane*LANE_W +: LANE_W] = (d < c) ? d : c;
                end
                MODE_MAX: begin
                    res[lane*LANE_W +: LANE_W] = (d > c) ? d : c;
                end
                default: begin
                    prod = {8'd0, d} * {8'd0, c} + {8'd0, LANE_MAX};
                    res[lane*LANE_W +: LANE_W] = prod[15:8];
                end
            endcase
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blended_q.delete();
            fill_color   <= '0;
            blend_mode   <= '0;
            alpha_mask   <= '0;
            blend_alpha  <= 1'b0;
            fail_total   = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (blended_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT) begin
                        $display("result %08h with no request waiting", i_res.out_pixel);
                    end
                end else begin
                    want = blended_q.pop_front();
                    if (i_res.out_pixel !== want) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("out_pixel mismatch: expected %08h, got %08h",
                                     want, i_res.out_pixel);
                        end
                    end
                end
            end
            if (i_dst.valid && i_dst.ready) begin
                blended_q.push_back(blend_pixel(i_dst.dst_pixel, fill_color, blend_mode,
                                                alpha_mask, blend_alpha));
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_FILL_COLOR:  fill_color  <= i_cfg.data;
                    CFG_BLEND_MODE:  blend_mode  <= i_cfg.data[MODE_W-1:0];
                    CFG_ALPHA_MASK:  alpha_mask  <= i_cfg.data;
                    CFG_BLEND_ALPHA: blend_alpha <= i_cfg.data[0];
                    default: ;
                endcase
            end
            o_fail_count <= fail_total;
            o_pending    <= blended_q.size();
        end
    end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the pixel fill blend regression: clock, reset, stimulus, stall pattern and verdict.
`default_nettype none
module testbench;
    import pfb_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 4;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MIX_COUNT      = 4;
    localparam int SETS_PER_MIX   = 7;
    localparam int ITEMS_PER_SET  = 50;

    // Idle mixes: none, sender only, receiver only, both.
    localparam int SEND_IDLE [MIX_COUNT] = '{0, 47, 0, 34};
    localparam int RECV_STALL[MIX_COUNT] = '{0, 0, 47, 34};

    // Mode codes past multiply pass the pixel through; index past the map is dropped.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam t_cfg_idx          CFG_STRAY_IDX = 8'd200;
    localparam t_cfg_idx          CFG_IDX_TOP   = 8'd255;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   cycle_count   = 0;
    int   pixel_count   = 0;
    int   setting_count = 0;
    int   fail_count;
    int   pending;

    pfb_cfg_if cfg_ch();
    pfb_dst_if dst_ch();
    pfb_out_if res_ch();

    pixel_fill_blend dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_dst   (dst_ch),
        .o_res   (res_ch)
    );

    pfb_blend_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_dst        (dst_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Stall the result side at random; drop ready for stall_pct of the cycles.
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: end the run if the block stops moving.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Put one register write on the config channel and hold it until taken.
    // Valid stays high so back-to-back writes need no gap; the caller lowers it.
    task automatic cfg_write(input t_cfg_idx idx, input t_pixel data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Write all four registers, optionally a stray index too, then release the channel.
    task automatic apply_setting(input t_pixel color, input t_pixel mode_data,
                                 input t_pixel mask, input t_pixel alpha_data,
                                 input logic stray);
        cfg_write(CFG_FILL_COLOR, color);
        cfg_write(CFG_BLEND_MODE, mode_data);
        cfg_write(CFG_ALPHA_MASK, mask);
        cfg_write(CFG_BLEND_ALPHA, alpha_data);
        if (stray) begin
            cfg_write(t_cfg_idx'($urandom_range(CFG_BLEND_ALPHA + 1, CFG_IDX_TOP)), $urandom());
        end
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        setting_count++;
    endtask

    // Offer one pixel request after a random idle stretch; hold it until accepted.
    task automatic send_pixel(input t_pixel pix);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            dst_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        dst_ch.valid     <= 1'b1;
        dst_ch.dst_pixel <= pix;
        do @(posedge i_clk); while (!dst_ch.ready);
        pixel_count++;
    endtask

    // Drop the request line and wait until every owed result has come back.
    task automatic settle();
        dst_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Directed setting: three pixels covering all-ones, all-zeros and mixed bytes.
    task automatic directed_setting(input t_pixel color, input t_pixel mode_data,
                                    input t_pixel mask, input t_pixel alpha_data,
                                    input logic stray);
        apply_setting(color, mode_data, mask, alpha_data, stray);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'h7F80_FE01);
        settle();
    endtask

    // Bytes lean toward 0x00 and 0xFF to hit saturation and the multiply corners.
    function automatic t_pixel pick_pixel();
        t_pixel pix;
        int     lane;
        for (lane = 0; lane < LANES; lane++) begin
            case ($urandom_range(0, 3))
                0:       pix[lane*LANE_W +: LANE_W] = '0;
                1:       pix[lane*LANE_W +: LANE_W] = LANE_MAX;
                default: pix[lane*LANE_W +: LANE_W] = t_lane'($urandom());
            endcase
        end
        return pix;
    endfunction

    initial begin
        t_pixel            color;
        t_pixel            mask;
        logic [MODE_W-1:0] mode;
        int                mix;
        int                set_idx;
        int                item;

        // Hold every input at a known value from time zero.
        i_rst_n          <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_FILL_COLOR;
        cfg_ch.data      <= '0;
        dst_ch.valid     <= 1'b0;
        dst_ch.dst_pixel <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: every mode, masks aligned and not, wide writes, stray index.
        directed_setting(32'h80FF_017F, t_pixel'(MODE_ADD), 32'hFF00_0000, 32'd0, 1'b0);
        directed_setting(32'h80FF_017F, t_pixel'(MODE_SUB), 32'hFF00_0000, 32'd1, 1'b0);
        directed_setting(32'h0000_0000, t_pixel'(MODE_MIN), 32'h00F0_0F01, 32'd0, 1'b0);
        directed_setting(32'hFFFF_FFFF, t_pixel'(MODE_MAX), 32'hFF00_0000, 32'd0, 1'b0);
        directed_setting(32'hFFFF_FFFF, t_pixel'(MODE_MUL), 32'h0000_0000, 32'd0, 1'b0);
        directed_setting(32'h0180_7FFF, t_pixel'(MODE_MUL), 32'hFF00_0000, 32'd0, 1'b0);
        // Wide data: only the low mode bits and the low alpha bit count.
        directed_setting(32'h1234_5678, {29'h1FFF_FFFF, MODE_SPARE_LO},
                         32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
        apply_setting(32'hA5A5_5A5A, {29'h0ABC_DEF0, MODE_SPARE_HI},
                      32'h0000_00FF, 32'hFFFF_FFFF, 1'b0);
        cfg_write(CFG_STRAY_IDX, 32'hDEAD_BEEF);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        settle();

        // Random part: several settings under each idle mix.
        for (mix = 0; mix < MIX_COUNT; mix++) begin
            send_idle_pct = SEND_IDLE[mix];
            stall_pct     = RECV_STALL[mix];
            for (set_idx = 0; set_idx < SETS_PER_MIX; set_idx++) begin
                case ($urandom_range(0, 3))
                    0:       color = '0;
                    1:       color = '1;
                    default: color = $urandom();
                endcase
                case ($urandom_range(0, 3))
                    0:       mask = '0;
                    1:       mask = 32'hFF00_0000;
                    2:       mask = 32'h0000_00FF;
                    default: mask = $urandom();
                endcase
                if ($urandom_range(0, 9) < 8) begin
                    mode = MODE_W'($urandom_range(MODE_ADD, MODE_MUL));
                end else begin
                    mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
                end
                // Keep random upper bits on the narrow registers.
                apply_setting(color, {29'($urandom()), mode}, mask,
                              $urandom(), ($urandom_range(0, 3) == 0));
                for (item = 0; item < ITEMS_PER_SET; item++) begin
                    send_pixel(pick_pixel());
                end
                settle();
            end
        end

        // Drain: wait until nothing is owed, then let the pipeline run empty.
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d pixel requests under %0d register settings", pixel_count,
                 setting_count);
        $display("all blend modes and unused codes, with idle on neither, either and both sides");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
